// File: design/qrr_pkg.sv
package qrr_pkg;

    // Fixed-point layout
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TANH_BITS  = 30;

    localparam logic [63:0] ONE_F    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ONE_T    = 64'd1 << TANH_BITS;
    localparam logic [63:0] TANH_SAT = 64'd16 << TANH_BITS;
    localparam logic [63:0] LN2_T    = 64'd744261118;
    localparam logic [63:0] MAX64    = {64{1'b1}};
    localparam logic [63:0] MASK32   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] WEQ_MAX  = 64'd1 << 62;
    localparam logic [63:0] MIN_PARAM_INV  = 64'd100000;
    localparam logic [63:0] MAX_INIT_RATIO = 64'd10;
    localparam logic [63:0] K_MAX    = 64'd40;
    localparam logic [3:0]  N_TERMS  = 4'd13;

    // Register reset values
    localparam logic [31:0] RST_TIMESTEP = 32'd65536;
    localparam logic [31:0] RST_SCALE    = 32'd65536;
    localparam logic [31:0] RST_REFOUT   = 32'd65536;
    localparam logic [31:0] RST_INIT     = 32'd0;

    // Register indexes
    localparam logic [1:0] CFG_TIMESTEP = 2'd0;
    localparam logic [1:0] CFG_SCALE    = 2'd1;
    localparam logic [1:0] CFG_REFOUT   = 2'd2;
    localparam logic [1:0] CFG_INIT     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_INIT  = 2'd2;

    typedef struct packed {
        logic signed [31:0] inflow;
        logic               inflow_missing;
        logic               end_of_series;
    } t_in;

    typedef struct packed {
        logic signed [31:0] outflow;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [31:0] timestep;
        logic [31:0] storage_scale;
        logic [31:0] reference_outflow;
        logic [31:0] initial_storage;
    } t_cfg;

    // Classified item passed from front to back
    typedef struct packed {
        logic [31:0] inflow;
        logic        use_prev;
        logic        last;
        logic [1:0]  status;
    } t_job;

endpackage

// File: design/quadratic_reservoir_routing.sv
// Quadratic reservoir routing: each input item carries one inflow sample and
// yields one result item with the routed outflow (Q15.16, saturated) and a
// status code. Invalid settings give a nonzero status, zero outflow and leave
// the series state untouched. Items are processed one at a time by a single
// sequencer that shares one 64x64 multiplier, one bit-serial divider, one
// square root unit and a subtract loop for the exp range reduction. A
// finished result waits in the sequencer while the output is stalled. A
// two-entry queue behind the input stage lets up to three items be accepted
// ahead of the sequencer.
// Registers are to be written through the plain write port only while the
// block is idle; the block itself does not enforce this.
module quadratic_reservoir_routing (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  qrr_pkg::t_in      i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output qrr_pkg::t_out     o_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);

    qrr_pkg::t_cfg r_cfg;
    qrr_pkg::t_job w_fjob;
    qrr_pkg::t_job w_qjob;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_qvalid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timestep          <= qrr_pkg::RST_TIMESTEP;
            r_cfg.storage_scale     <= qrr_pkg::RST_SCALE;
            r_cfg.reference_outflow <= qrr_pkg::RST_REFOUT;
            r_cfg.initial_storage   <= qrr_pkg::RST_INIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qrr_pkg::CFG_TIMESTEP: r_cfg.timestep          <= i_cfg_data;
                qrr_pkg::CFG_SCALE:    r_cfg.storage_scale     <= i_cfg_data;
                qrr_pkg::CFG_REFOUT:   r_cfg.reference_outflow <= i_cfg_data;
                qrr_pkg::CFG_INIT:     r_cfg.initial_storage   <= i_cfg_data;
                default:               r_cfg.timestep          <= r_cfg.timestep;
            endcase
        end
    end

    qrr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_job   (w_fjob)
    );

    qrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    qrr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_qvalid),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

// File: design/qrr_front.sv
module qrr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qrr_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  qrr_pkg::t_in      i_item,
    output logic              o_push,
    input  logic              i_full,
    output qrr_pkg::t_job     o_job
);

    logic          r_valid;
    qrr_pkg::t_job r_job;
    qrr_pkg::t_job w_job;
    logic [63:0]   w_th_chk;
    logic [63:0]   w_q0_chk;
    logic [63:0]   w_init_lim;
    logic          w_accept;

    // Settings check and sample classification
    always_comb begin
        w_th_chk   = 64'(i_cfg.storage_scale) * qrr_pkg::MIN_PARAM_INV;
        w_q0_chk   = 64'(i_cfg.reference_outflow) * qrr_pkg::MIN_PARAM_INV;
        w_init_lim = 64'(i_cfg.storage_scale) * qrr_pkg::MAX_INIT_RATIO;
        w_job.inflow   = i_item.inflow;
        w_job.use_prev = i_item.inflow_missing | i_item.inflow[31];
        w_job.last     = i_item.end_of_series;
        if (w_th_chk < qrr_pkg::ONE_F || w_q0_chk < qrr_pkg::ONE_F
            || i_cfg.timestep == '0) begin
            w_job.status = qrr_pkg::ST_PARAM;
        end else if (64'(i_cfg.initial_storage) > w_init_lim) begin
            w_job.status = qrr_pkg::ST_INIT;
        end else begin
            w_job.status = qrr_pkg::ST_OK;
        end
    end

    assign o_stall  = r_valid & i_full;
    assign w_accept = i_valid & ~o_stall;
    assign o_push   = r_valid & ~i_full;
    assign o_job    = r_job;

    // One holding stage in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_job <= w_job;
        end
    end

endmodule

// File: design/qrr_queue.sv
module qrr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qrr_pkg::t_job     i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output qrr_pkg::t_job     o_job
);

    qrr_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // Two-entry FIFO between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: design/qrr_back.sv
module qrr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qrr_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  qrr_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output qrr_pkg::t_out     o_item
);

    typedef enum logic [6:0] {
        E_IDLE = 7'b0000001,
        E_MUL  = 7'b0000010,
        E_DIV  = 7'b0000100,
        E_ROOT = 7'b0001000,
        E_NEXT = 7'b0010000,
        E_OUT  = 7'b0100000,
        E_RED  = 7'b1000000
    } t_eng;

    typedef enum logic [11:0] {
        P_ROOT = 12'b000000000001,
        P_WEQ  = 12'b000000000010,
        P_H    = 12'b000000000100,
        P_G    = 12'b000000001000,
        P_X    = 12'b000000010000,
        P_K    = 12'b000000100000,
        P_TM   = 12'b000001000000,
        P_TH   = 12'b000010000000,
        P_P    = 12'b000100000000,
        P_Q    = 12'b001000000000,
        P_S1   = 12'b010000000000,
        P_D    = 12'b100000000000
    } t_step;

    // What follows a product; M_SHIFT drops the Q.30 fraction
    typedef enum logic [1:0] {
        M_SHIFT = 2'd0,
        M_DIV   = 2'd1,
        M_DIVSH = 2'd2,
        M_ROOT  = 2'd3
    } t_mode;

    localparam logic signed [65:0] OUT_MAX =
        66'sd1 <<< (qrr_pkg::DATA_WIDTH - 1);
    localparam logic signed [65:0] SAT_HI = OUT_MAX - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -OUT_MAX;

    t_eng   r_state;
    t_step  r_step;
    t_mode  r_mode;
    logic   r_running;
    logic   r_ovalid;
    logic [1:0]  r_ostat;
    logic [31:0] r_oflow;
    qrr_pkg::t_out r_oitem;

    // Series state
    logic [31:0] r_stor;
    logic [31:0] r_prev;

    // Per-item working registers
    logic [31:0] r_s0;
    logic [31:0] r_qi;
    logic        r_last;
    logic [31:0] r_sr;
    logic [63:0] r_weq;
    logic [63:0] r_w;
    logic [5:0]  r_k;
    logic [63:0] r_r;
    logic [63:0] r_sum;
    logic [3:0]  r_n;
    logic [63:0] r_p;
    logic [31:0] r_s1;
    logic        r_neg;
    logic [63:0] r_res;

    // Shared multiplier
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic [127:0] r_acc;
    logic [1:0]   r_mcnt;

    // Shared bit-serial divider
    logic [127:0] r_dvd;
    logic [63:0]  r_dc;
    logic [63:0]  r_rem;
    logic [63:0]  r_quo;
    logic         r_sat;
    logic [6:0]   r_dcnt;

    // Square root unit
    logic [63:0] r_rx;
    logic [63:0] r_rr;
    logic [63:0] r_rbit;
    logic [4:0]  r_rcnt;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_pp;
    logic [1:0]   w_sh;
    logic [127:0] w_acc_n;
    logic [64:0]  w_rem65;
    logic         w_dge;
    logic [63:0]  w_rem_n;
    logic [63:0]  w_quo_n;
    logic [63:0]  w_rt;
    logic         w_rge;
    logic [63:0]  w_rr_n;
    logic [31:0]  w_s0_sel;
    logic [31:0]  w_qi_sel;
    logic [63:0]  w_den;
    logic [63:0]  w_sum_n;
    logic [63:0]  w_e;
    logic [31:0]  w_s1c;
    logic [31:0]  w_diff;
    logic signed [65:0] w_qsum;
    logic [31:0]  w_qout;

    // Multiplier: one 32x32 partial product per cycle
    always_comb begin
        w_ah    = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
        w_bh    = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp    = 64'(w_ah) * 64'(w_bh);
        w_sh    = 2'(r_mcnt[1]) + 2'(r_mcnt[0]);
        w_acc_n = r_acc + ({64'd0, w_pp} << {w_sh, 5'd0});
    end

    // Divider: one quotient bit per cycle
    always_comb begin
        w_rem65 = {r_rem, r_dvd[127]};
        w_dge   = (w_rem65 >= {1'b0, r_dc});
        w_rem_n = w_dge ? 64'(w_rem65 - {1'b0, r_dc}) : w_rem65[63:0];
        w_quo_n = {r_quo[62:0], w_dge};
    end

    // Root: one result bit per cycle
    always_comb begin
        w_rt   = r_rr + r_rbit;
        w_rge  = (r_rx >= w_rt);
        w_rr_n = w_rge ? ((r_rr >> 1) + r_rbit) : (r_rr >> 1);
    end

    // Item setup and step results
    always_comb begin
        w_s0_sel = r_running ? r_stor : i_cfg.initial_storage;
        w_qi_sel = i_job.use_prev ? (r_running ? r_prev : 32'd0) : i_job.inflow;
        w_den    = (r_res > qrr_pkg::MAX64 - qrr_pkg::ONE_T) ?
                   qrr_pkg::MAX64 : qrr_pkg::ONE_T + r_res;
        w_sum_n  = r_n[0] ? r_sum - r_res : r_sum + r_res;
        w_e      = w_sum_n >> r_k;
        w_s1c    = (r_res > qrr_pkg::MASK32) ? 32'hFFFF_FFFF : r_res[31:0];
        w_diff   = (r_s0 < w_s1c) ? w_s1c - r_s0 : r_s0 - w_s1c;
        w_qsum   = r_neg ? $signed({34'd0, r_qi}) - $signed({2'd0, r_res})
                         : $signed({34'd0, r_qi}) + $signed({2'd0, r_res});
        if (w_qsum > SAT_HI) begin
            w_qout = SAT_HI[31:0];
        end else if (w_qsum < SAT_LO) begin
            w_qout = SAT_LO[31:0];
        end else begin
            w_qout = w_qsum[31:0];
        end
    end

    assign o_pop   = (r_state == E_IDLE) && i_q_valid;
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_running <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != E_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                E_IDLE: begin
                    r_acc  <= '0;
                    r_mcnt <= '0;
                    if (i_q_valid) begin
                        r_last <= i_job.last;
                        if (i_job.status != qrr_pkg::ST_OK) begin
                            r_ostat <= i_job.status;
                            r_oflow <= '0;
                            r_state <= E_OUT;
                        end else begin
                            r_ostat <= qrr_pkg::ST_OK;
                            r_s0    <= w_s0_sel;
                            r_qi    <= w_qi_sel;
                            r_ma    <= 64'(w_qi_sel);
                            r_mb    <= 64'(i_cfg.reference_outflow);
                            r_mode  <= M_ROOT;
                            r_step  <= P_ROOT;
                            r_state <= E_MUL;
                        end
                    end
                end
                E_MUL: begin
                    r_acc  <= w_acc_n;
                    r_mcnt <= r_mcnt + 2'd1;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_sat  <= 1'b0;
                    r_dcnt <= '0;
                    if (r_mcnt == 2'd3) begin
                        case (r_mode)
                            M_SHIFT: begin
                                r_res   <= (|w_acc_n[127:94]) ? qrr_pkg::MAX64
                                                             : w_acc_n[93:30];
                                r_state <= E_NEXT;
                            end
                            M_DIV: begin
                                r_dvd   <= w_acc_n;
                                r_state <= E_DIV;
                            end
                            M_DIVSH: begin
                                r_dvd   <= {64'd0, w_acc_n[93:30]};
                                r_state <= E_DIV;
                            end
                            M_ROOT: begin
                                r_rx    <= w_acc_n[63:0];
                                r_rr    <= '0;
                                r_rbit  <= qrr_pkg::WEQ_MAX;
                                r_rcnt  <= '0;
                                r_state <= E_ROOT;
                            end
                            default: r_state <= E_IDLE;
                        endcase
                    end
                end
                E_DIV: begin
                    r_rem  <= w_rem_n;
                    r_quo  <= w_quo_n;
                    r_sat  <= r_sat | r_quo[63];
                    r_dvd  <= r_dvd << 1;
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd127) begin
                        r_res   <= (r_sat | r_quo[63]) ? qrr_pkg::MAX64 : w_quo_n;
                        r_state <= E_NEXT;
                    end
                end
                E_ROOT: begin
                    if (w_rge) begin
                        r_rx <= r_rx - w_rt;
                    end
                    r_rr   <= w_rr_n;
                    r_rbit <= r_rbit >> 2;
                    r_rcnt <= r_rcnt + 5'd1;
                    if (r_rcnt == 5'd31) begin
                        r_res   <= w_rr_n;
                        r_state <= E_NEXT;
                    end
                end
                // Range reduction y = k*ln2 + r by repeated subtraction, stopping
                // once r is below ln2 or k is past the underflow limit
                E_RED: begin
                    if (r_r >= qrr_pkg::LN2_T && 64'(r_k) <= qrr_pkg::K_MAX) begin
                        r_r <= r_r - qrr_pkg::LN2_T;
                        r_k <= r_k + 6'd1;
                    end else begin
                        r_state <= E_NEXT;
                    end
                end
                E_NEXT: begin
                    r_acc   <= '0;
                    r_mcnt  <= '0;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_sat   <= 1'b0;
                    r_dcnt  <= '0;
                    case (r_step)
                        // equilibrium storage W = theta*sr/q0
                        P_ROOT: begin
                            r_sr    <= r_res[31:0];
                            r_ma    <= 64'(i_cfg.storage_scale);
                            r_mb    <= r_res;
                            r_dc    <= 64'(i_cfg.reference_outflow);
                            r_mode  <= M_DIV;
                            r_step  <= P_WEQ;
                            r_state <= E_MUL;
                        end
                        P_WEQ: begin
                            r_weq   <= (r_res > qrr_pkg::WEQ_MAX) ? qrr_pkg::WEQ_MAX : r_res;
                            r_dc    <= 64'(i_cfg.storage_scale);
                            r_mode  <= M_DIV;
                            r_state <= E_MUL;
                            if (r_res == '0) begin
                                r_ma   <= 64'(r_s0);
                                r_mb   <= 64'(i_cfg.reference_outflow);
                                r_step <= P_H;
                            end else begin
                                r_ma   <= 64'(r_sr) << (qrr_pkg::TANH_BITS - qrr_pkg::FRAC_BITS);
                                r_mb   <= 64'(i_cfg.timestep);
                                r_step <= P_X;
                            end
                        end
                        // zero-equilibrium limit
                        P_H: begin
                            r_ma    <= r_res;
                            r_mb    <= 64'(i_cfg.timestep)
                                       << (qrr_pkg::TANH_BITS - qrr_pkg::FRAC_BITS);
                            r_dc    <= 64'(i_cfg.storage_scale);
                            r_mode  <= M_DIV;
                            r_step  <= P_G;
                            r_state <= E_MUL;
                        end
                        P_G: begin
                            r_ma    <= 64'(r_s0);
                            r_mb    <= qrr_pkg::ONE_T;
                            r_dc    <= w_den;
                            r_mode  <= M_DIV;
                            r_step  <= P_S1;
                            r_state <= E_MUL;
                        end
                        // tanh argument, saturate or start exp(-2x)
                        P_X: begin
                            if (r_res >= qrr_pkg::TANH_SAT) begin
                                r_w     <= qrr_pkg::ONE_T;
                                r_ma    <= r_weq;
                                r_mb    <= qrr_pkg::ONE_T;
                                r_mode  <= M_SHIFT;
                                r_step  <= P_P;
                                r_state <= E_MUL;
                            end else begin
                                r_r     <= r_res << 1;
                                r_k     <= '0;
                                r_step  <= P_K;
                                r_state <= E_RED;
                            end
                        end
                        // exp underflows to zero, so tanh is one; else start the Taylor series
                        P_K: begin
                            if (64'(r_k) > qrr_pkg::K_MAX) begin
                                r_w     <= qrr_pkg::ONE_T;
                                r_ma    <= r_weq;
                                r_mb    <= qrr_pkg::ONE_T;
                                r_mode  <= M_SHIFT;
                                r_step  <= P_P;
                                r_state <= E_MUL;
                            end else begin
                                // Taylor series of exp(-r) starts at one, with r as the next term
                                r_res   <= r_r;
                                r_sum   <= qrr_pkg::ONE_T;
                                r_n     <= 4'd1;
                                r_step  <= P_TM;
                                r_state <= E_NEXT;
                            end
                        end
                        // Taylor series of exp(-r)
                        P_TM: begin
                            r_sum <= w_sum_n;
                            if (r_n == qrr_pkg::N_TERMS) begin
                                r_dvd   <= {64'd0, (qrr_pkg::ONE_T - w_e)
                                                   << qrr_pkg::TANH_BITS};
                                r_dc    <= qrr_pkg::ONE_T + w_e;
                                r_step  <= P_TH;
                                r_state <= E_DIV;
                            end else begin
                                r_n     <= r_n + 4'd1;
                                r_ma    <= r_res;
                                r_mb    <= r_r;
                                r_dc    <= 64'(r_n + 4'd1);
                                r_mode  <= M_DIVSH;
                                r_step  <= P_TM;
                                r_state <= E_MUL;
                            end
                        end
                        P_TH: begin
                            r_w     <= r_res;
                            r_ma    <= r_weq;
                            r_mb    <= r_res;
                            r_mode  <= M_SHIFT;
                            r_step  <= P_P;
                            r_state <= E_MUL;
                        end
                        // storage update s1 = W*(s0+p)/(W+q)
                        P_P: begin
                            r_p     <= r_res;
                            r_ma    <= 64'(r_s0);
                            r_mb    <= r_w;
                            r_mode  <= M_SHIFT;
                            r_step  <= P_Q;
                            r_state <= E_MUL;
                        end
                        P_Q: begin
                            r_ma    <= r_weq;
                            r_mb    <= 64'(r_s0) + r_p;
                            r_dc    <= r_weq + r_res;
                            r_mode  <= M_DIV;
                            r_step  <= P_S1;
                            r_state <= E_MUL;
                        end
                        // mass balance
                        P_S1: begin
                            r_s1    <= w_s1c;
                            r_neg   <= (r_s0 < w_s1c);
                            r_ma    <= 64'(w_diff);
                            r_mb    <= qrr_pkg::ONE_F;
                            r_dc    <= 64'(i_cfg.timestep);
                            r_mode  <= M_DIV;
                            r_step  <= P_D;
                            r_state <= E_MUL;
                        end
                        P_D: begin
                            r_oflow <= w_qout;
                            r_state <= E_OUT;
                        end
                        default: r_state <= E_IDLE;
                    endcase
                end
                E_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid       <= 1'b1;
                        r_oitem.outflow <= $signed(r_oflow);
                        r_oitem.status  <= r_ostat;
                        r_state        <= E_IDLE;
                        if (r_ostat == qrr_pkg::ST_OK) begin
                            if (r_last) begin
                                r_running <= 1'b0;
                            end else begin
                                r_running <= 1'b1;
                                r_stor    <= r_s1;
                                r_prev    <= r_qi;
                            end
                        end
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

// File: design/qrr_checker.sv
module qrr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input qrr_pkg::t_out o_item
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // Error results carry zero outflow
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status != qrr_pkg::ST_OK) |-> o_item.outflow == '0)
        else $error("error result with nonzero outflow");

    // Only defined status codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.status == qrr_pkg::ST_OK
                     || o_item.status == qrr_pkg::ST_PARAM
                     || o_item.status == qrr_pkg::ST_INIT))
        else $error("undefined status code");

    // No result right out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind quadratic_reservoir_routing qrr_checker u_chk (.*);
